### rtl/cursor_table_interpolator_top_defines.svh
// Assertion macros used by cursor_table_interpolator_top
`ifndef CURSOR_TABLE_INTERPOLATOR_TOP_DEFINES_SVH
`define CURSOR_TABLE_INTERPOLATOR_TOP_DEFINES_SVH

// Same-cycle implication under reset
`define CTI_ASSERT_NOW(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// Next-cycle implication under reset
`define CTI_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

### rtl/ctinterp_pkg.sv
package ctinterp_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int CW = 11;
    localparam int DW = 32;
    localparam int OPW = 33;
    localparam int PW = 66;
    localparam int QW = 34;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_SEEK = 2'd1;
    localparam logic [1:0] OP_EVAL = 2'd2;

    localparam logic [1:0] MODE_BACK = 2'd0;
    localparam logic [1:0] MODE_FWD = 2'd1;
    localparam logic [1:0] MODE_LIN = 2'd2;

    localparam logic [1:0] REG_LENGTH = 2'd0;
    localparam logic [1:0] REG_MODE = 2'd1;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_PAST_END = 2'd1;
    localparam logic [1:0] ST_BEFORE = 2'd2;

    typedef struct packed {
        logic start;
        logic [OPW-1:0] ady;
        logic [OPW-1:0] adq;
        logic [OPW-1:0] adt;
    } md_req_t;

    typedef struct packed {
        logic done;
        logic [QW-1:0] quot;
    } md_resp_t;

endpackage

### rtl/ctinterp_ram.sv
module ctinterp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read one entry registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/ctinterp_muldiv.sv
module ctinterp_muldiv (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctinterp_pkg::md_req_t  req,
    output ctinterp_pkg::md_resp_t resp
);

    typedef enum logic [5:0] {
        MD_IDLE = 6'b000001,
        MD_MLO  = 6'b000010,
        MD_MHI  = 6'b000100,
        MD_SUM  = 6'b001000,
        MD_DIV  = 6'b010000,
        MD_FIN  = 6'b100000
    } md_state_t;

    localparam int CNTW = $clog2(ctinterp_pkg::PW);
    localparam logic [CNTW-1:0] LAST = CNTW'(ctinterp_pkg::PW - 1);
    localparam logic [ctinterp_pkg::PW-1:0] QMAX = ctinterp_pkg::PW'(1) << 33;

    md_state_t state_reg, state_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [ctinterp_pkg::OPW-1:0] a_reg, b_reg, d_reg;
    logic [48:0] plo_reg;
    logic [49:0] phi_reg;
    logic [ctinterp_pkg::PW-1:0] dq_reg;
    logic [ctinterp_pkg::QW-1:0] rem_reg;
    logic [ctinterp_pkg::QW-1:0] rem_sh;
    logic take;

    // Shift in one dividend bit and try the subtraction
    assign rem_sh = {rem_reg[ctinterp_pkg::QW-2:0], dq_reg[ctinterp_pkg::PW-1]};
    assign take = rem_sh >= {1'b0, d_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        case (state_reg)
            MD_IDLE: if (req.start) state_next = MD_MLO;
            MD_MLO:  state_next = MD_MHI;
            MD_MHI:  state_next = MD_SUM;
            MD_SUM:
            begin
                state_next = MD_DIV;
                cnt_next = '0;
            end
            MD_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST) state_next = MD_FIN;
            end
            MD_FIN:  state_next = MD_IDLE;
            default: state_next = MD_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    // Partial products, then restoring division one bit a cycle
    always_ff @(posedge clk)
    begin
        case (state_reg)
            MD_IDLE:
            begin
                a_reg <= req.ady;
                b_reg <= req.adq;
                d_reg <= req.adt;
            end
            MD_MLO: plo_reg <= a_reg * b_reg[15:0];
            MD_MHI: phi_reg <= a_reg * b_reg[32:16];
            MD_SUM:
            begin
                dq_reg <= ctinterp_pkg::PW'(plo_reg) + (ctinterp_pkg::PW'(phi_reg) << 16);
                rem_reg <= '0;
            end
            MD_DIV:
            begin
                rem_reg <= take ? rem_sh - {1'b0, d_reg} : rem_sh;
                dq_reg <= {dq_reg[ctinterp_pkg::PW-2:0], take};
            end
            default:
            begin
            end
        endcase
    end

    // Clamp the quotient at two to the 33rd
    assign resp.done = state_reg == MD_FIN;
    assign resp.quot = (dq_reg > QMAX) ? QMAX[ctinterp_pkg::QW-1:0]
                                       : dq_reg[ctinterp_pkg::QW-1:0];

endmodule

### rtl/cursor_table_interpolator_top.sv
// Flow, input beat to result beat: write and unknown items go straight to the result;
// seek reads the middle entry and halves the search window per step.
// Evaluate walks past table entries one read each, then answers past the end, exact,
// forward or before start, backward or for equal times, or by a linear blend.
// One item in flight at a time; the 66-step restoring divider and the walk set the rate.
// Reset clears cursor, active flag, output valid; length 0 and mode linear; table undefined.
`include "cursor_table_interpolator_top_defines.svh"

module cursor_table_interpolator_top #(
    parameter int TABLE_DEPTH = ctinterp_pkg::TABLE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [10:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         operation,
    input  logic [9:0]         entry_index,
    input  logic signed [31:0] entry_time,
    input  logic signed [31:0] entry_value,
    input  logic signed [31:0] query_year,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] change_value,
    output logic [1:0]         status,
    output logic               active,
    output logic [10:0]        cursor_position
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = ctinterp_pkg::CW;

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_SEEK_RD   = 9'b000000010,
        S_SEEK_CMP  = 9'b000000100,
        S_WALK_RD   = 9'b000001000,
        S_WALK_CMP  = 9'b000010000,
        S_PREV      = 9'b000100000,
        S_LERP_GO   = 9'b001000000,
        S_LERP_WAIT = 9'b010000000,
        S_DONE      = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] len_reg, cursor_reg, cursor_next, l_reg, l_next, r_reg, r_next;
    logic [1:0] mode_reg;
    logic active_reg, active_next;
    logic signed [31:0] q_reg;
    logic signed [31:0] t1_reg, y1_reg, y0_reg, chg_reg, chg_next;
    logic [1:0] stat_reg, stat_next;
    logic signed [31:0] t1_next, y1_next, y0_next;
    logic [ctinterp_pkg::OPW-1:0] ady_reg, adq_reg, adt_reg;
    logic neg_reg;
    logic [CW-1:0] len_eff, mid, raddr_c;
    logic [CW:0] lr_sum;
    logic [AW+CW-1:0] raddr_wide;
    logic [AW+9:0] waddr_wide;
    logic [AW-1:0] raddr;
    logic [63:0] rdata;
    logic we;
    logic accept;
    logic out_load;
    logic signed [31:0] rd_time, rd_val;
    logic signed [32:0] dt, dy, dq;
    logic signed [35:0] lsum;
    logic signed [31:0] lsat;
    ctinterp_pkg::md_req_t md_req;
    ctinterp_pkg::md_resp_t md_resp;

    assign accept = in_valid && !in_stall;
    assign in_stall = state_reg != S_IDLE;
    assign len_eff = (32'(len_reg) < TABLE_DEPTH) ? len_reg : CW'(TABLE_DEPTH);
    assign lr_sum = {1'b0, l_reg} + {1'b0, r_reg};
    assign mid = lr_sum[CW:1];
    assign rd_time = rdata[63:32];
    assign rd_val = rdata[31:0];

    // Table write straight from the accepted beat
    assign we = accept && operation == ctinterp_pkg::OP_WRITE
                && 32'(entry_index) < TABLE_DEPTH;
    assign waddr_wide = {{AW{1'b0}}, entry_index};
    assign raddr_wide = {{AW{1'b0}}, raddr_c};
    assign raddr = raddr_wide[AW-1:0];

    ctinterp_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr_wide[AW-1:0]),
        .wdata ({entry_time, entry_value}),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign md_req.start = state_reg == S_LERP_GO;
    assign md_req.ady = ady_reg;
    assign md_req.adq = adq_reg;
    assign md_req.adt = adt_reg;

    ctinterp_muldiv u_md (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .resp  (md_resp)
    );

    // Differences for the linear step, from the previous entry
    assign dt = 33'(t1_reg) - 33'(rd_time);
    assign dy = 33'(y1_reg) - 33'(rd_val);
    assign dq = 33'(q_reg) - 33'(rd_time);

    // Add the quotient to y0, or subtract it when negative, and saturate
    assign lsum = neg_reg ? 36'(y0_reg) - $signed({2'b00, md_resp.quot})
                          : 36'(y0_reg) + $signed({2'b00, md_resp.quot});
    assign lsat = (lsum > 36'sh07FFFFFFF) ? 32'sh7FFFFFFF
                : (lsum < -36'sh080000000) ? -32'sh80000000 : lsum[31:0];

    assign out_load = state_reg == S_DONE && (!out_valid || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        cursor_next = cursor_reg;
        active_next = active_reg;
        l_next = l_reg;
        r_next = r_reg;
        chg_next = chg_reg;
        stat_next = stat_reg;
        t1_next = t1_reg;
        y1_next = y1_reg;
        y0_next = y0_reg;
        raddr_c = cursor_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    chg_next = '0;
                    stat_next = ctinterp_pkg::ST_OK;
                    l_next = '0;
                    r_next = len_eff;
                    case (operation)
                        ctinterp_pkg::OP_SEEK: state_next = S_SEEK_RD;
                        ctinterp_pkg::OP_EVAL: state_next = S_WALK_RD;
                        default:               state_next = S_DONE;
                    endcase
                end
            end
            S_SEEK_RD:
            begin
                raddr_c = mid;
                if ({1'b0, r_reg} > {1'b0, l_reg} + 1'b1)
                begin
                    state_next = S_SEEK_CMP;
                end
                else
                begin
                    cursor_next = l_reg;
                    if (l_reg >= len_eff)
                    begin
                        active_next = 1'b0;
                        stat_next = ctinterp_pkg::ST_PAST_END;
                    end
                    else
                    begin
                        active_next = 1'b1;
                    end
                    state_next = S_DONE;
                end
            end
            S_SEEK_CMP:
            begin
                // Halve the search window
                if (q_reg < rd_time) r_next = mid;
                else l_next = mid;
                state_next = S_SEEK_RD;
            end
            S_WALK_RD:
            begin
                if (cursor_reg < len_eff)
                begin
                    state_next = S_WALK_CMP;
                end
                else
                begin
                    active_next = 1'b0;
                    stat_next = ctinterp_pkg::ST_PAST_END;
                    state_next = S_DONE;
                end
            end
            S_WALK_CMP:
            begin
                raddr_c = cursor_reg - 1'b1;
                t1_next = rd_time;
                y1_next = rd_val;
                if (q_reg > rd_time)
                begin
                    cursor_next = cursor_reg + 1'b1;
                    state_next = S_WALK_RD;
                end
                else if (q_reg == rd_time || mode_reg == ctinterp_pkg::MODE_FWD)
                begin
                    chg_next = rd_val;
                    state_next = S_DONE;
                end
                else if (cursor_reg == '0)
                begin
                    stat_next = ctinterp_pkg::ST_BEFORE;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_PREV;
                end
            end
            S_PREV:
            begin
                y0_next = rd_val;
                if (mode_reg == ctinterp_pkg::MODE_BACK || dt == '0)
                begin
                    chg_next = rd_val;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_LERP_GO;
                end
            end
            S_LERP_GO: state_next = S_LERP_WAIT;
            S_LERP_WAIT:
            begin
                if (md_resp.done)
                begin
                    chg_next = lsat;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cursor_reg <= '0;
            active_reg <= 1'b0;
            len_reg <= '0;
            mode_reg <= ctinterp_pkg::MODE_LIN;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cursor_reg <= cursor_next;
            active_reg <= active_next;
            if (cfg_we && cfg_index == ctinterp_pkg::REG_LENGTH) len_reg <= cfg_data;
            if (cfg_we && cfg_index == ctinterp_pkg::REG_MODE) mode_reg <= cfg_data[1:0];
            if (out_load) out_valid <= 1'b1;
            else if (!out_stall) out_valid <= 1'b0;
        end
    end

    // Working payload and result beat
    always_ff @(posedge clk)
    begin
        if (accept) q_reg <= query_year;
        l_reg <= l_next;
        r_reg <= r_next;
        chg_reg <= chg_next;
        stat_reg <= stat_next;
        t1_reg <= t1_next;
        y1_reg <= y1_next;
        y0_reg <= y0_next;
        if (state_reg == S_PREV)
        begin
            adt_reg <= dt[32] ? 33'(-dt) : 33'(dt);
            ady_reg <= dy[32] ? 33'(-dy) : 33'(dy);
            adq_reg <= dq[32] ? 33'(-dq) : 33'(dq);
            neg_reg <= (dt[32] ^ dy[32]) ^ dq[32];
        end
        if (out_load)
        begin
            change_value <= chg_reg;
            status <= stat_reg;
            active <= active_reg;
            cursor_position <= cursor_reg;
        end
    end

    `CTI_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, in_stall)
    `CTI_ASSERT_NOW(a_md_done_wait, clk, rst_n, md_resp.done, state_reg == S_LERP_WAIT)
    `CTI_ASSERT_NOW(a_load_idle, clk, rst_n, out_load, state_next == S_IDLE)
    `CTI_ASSERT_NEXT(a_past_end_inactive, clk, rst_n,
        out_load && stat_reg == ctinterp_pkg::ST_PAST_END, !active)

endmodule

### test/cursor_table_checker.sv
`timescale 1ns / 1ps

module cursor_table_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [10:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [1:0]         operation,
    input  logic [9:0]         entry_index,
    input  logic signed [31:0] entry_time,
    input  logic signed [31:0] entry_value,
    input  logic signed [31:0] query_year,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] change_value,
    input  logic [1:0]         status,
    input  logic               active,
    input  logic [10:0]        cursor_position,
    output int                 errors,
    output int                 outstanding,
    output int                 results_seen,
    output int                 evals_seen,
    output int                 lerps_seen
);

    typedef struct packed {
        logic signed [31:0] change;
        logic [1:0]         st;
        logic               act;
        logic [10:0]        cur;
    } forcing_t;

    logic signed [31:0] times_m [ctinterp_pkg::TABLE_DEPTH];
    logic signed [31:0] values_m [ctinterp_pkg::TABLE_DEPTH];
    int unsigned        cursor_m;
    bit                 active_m;
    int unsigned        length_m;
    logic [1:0]         mode_m;
    forcing_t           forcing_q [$];

    // y0 + (y1-y0)*(q-t0)/(t1-t0), quotient truncated, sum saturated
    function automatic logic signed [31:0] blend_linear(
        input logic signed [31:0] t0, input logic signed [31:0] t1,
        input logic signed [31:0] y0, input logic signed [31:0] y1,
        input logic signed [31:0] q);
        longint     dt, dy, dq, sum;
        logic [65:0] adt, ady, adq, quot;
        bit         neg;
        dt = longint'(t1) - longint'(t0);
        dy = longint'(y1) - longint'(y0);
        dq = longint'(q) - longint'(t0);
        if (dt == 0)
            return y0;
        adt = (dt < 0) ? -dt : dt;
        ady = (dy < 0) ? -dy : dy;
        adq = (dq < 0) ? -dq : dq;
        neg = ((dt < 0) != (dy < 0)) != (dq < 0);
        quot = (ady * adq) / adt;
        if (quot > (66'd1 << 33))
            quot = 66'd1 << 33;
        sum = neg ? longint'(y0) - longint'({30'd0, quot[33:0]})
                  : longint'(y0) + longint'({30'd0, quot[33:0]});
        if (sum > 64'sd2147483647)
            return 32'sh7fffffff;
        if (sum < -64'sd2147483648)
            return 32'sh80000000;
        return sum[31:0];
    endfunction

    // Advance the copied state by one item and return its result beat
    function automatic forcing_t predict_forcing(
        input logic [1:0] op, input logic [9:0] slot,
        input logic signed [31:0] t, input logic signed [31:0] v,
        input logic signed [31:0] q);
        forcing_t    res;
        int unsigned len, lo, hi, mid, c;
        res = '0;
        len = (length_m < ctinterp_pkg::TABLE_DEPTH) ? length_m : ctinterp_pkg::TABLE_DEPTH;
        case (op)
            ctinterp_pkg::OP_WRITE:
            begin
                times_m[slot] = t;
                values_m[slot] = v;
            end
            ctinterp_pkg::OP_SEEK:
            begin
                lo = 0;
                hi = len;
                while (hi > lo + 1)
                begin
                    mid = (lo + hi) / 2;
                    if (q < times_m[mid])
                        hi = mid;
                    else
                        lo = mid;
                end
                cursor_m = lo;
                if (lo >= len)
                begin
                    active_m = 0;
                    res.st = ctinterp_pkg::ST_PAST_END;
                end
                else
                    active_m = 1;
            end
            ctinterp_pkg::OP_EVAL:
            begin
                evals_seen++;
                while (cursor_m < len && q > times_m[cursor_m])
                    cursor_m++;
                c = cursor_m;
                if (c >= len)
                begin
                    active_m = 0;
                    res.st = ctinterp_pkg::ST_PAST_END;
                end
                else if (q == times_m[c] || mode_m == ctinterp_pkg::MODE_FWD)
                    res.change = values_m[c];
                else if (c == 0)
                    res.st = ctinterp_pkg::ST_BEFORE;
                else if (mode_m == ctinterp_pkg::MODE_BACK)
                    res.change = values_m[c - 1];
                else
                begin
                    lerps_seen++;
                    res.change = blend_linear(times_m[c - 1], times_m[c],
                                              values_m[c - 1], values_m[c], q);
                end
            end
            default:
            begin
            end
        endcase
        res.act = active_m;
        res.cur = cursor_m[10:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        forcing_t want, got;
        if (!rst_n)
        begin
            cursor_m = 0;
            active_m = 0;
            length_m = 0;
            mode_m = ctinterp_pkg::MODE_LIN;
            forcing_q.delete();
            errors = 0;
            outstanding = 0;
            results_seen = 0;
            evals_seen = 0;
            lerps_seen = 0;
        end
        else
        begin
            // track register writes
            if (cfg_we)
            begin
                if (cfg_index == ctinterp_pkg::REG_LENGTH)
                    length_m = cfg_data;
                else if (cfg_index == ctinterp_pkg::REG_MODE)
                    mode_m = cfg_data[1:0];
            end
            // predict each accepted input beat
            if (in_valid && !in_stall)
                forcing_q.push_back(predict_forcing(operation, entry_index, entry_time,
                                                    entry_value, query_year));
            // compare each accepted result beat with the oldest prediction
            if (out_valid && !out_stall)
            begin
                results_seen++;
                got = '{change_value, status, active, cursor_position};
                if (forcing_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result beat: change %0d status %0d",
                                 change_value, status);
                end
                else
                begin
                    want = forcing_q.pop_front();
                    if (want !== got)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: expected change %0d status %0d active %0d ",
                                      "cursor %0d, got change %0d status %0d active %0d ",
                                      "cursor %0d"}, want.change, want.st, want.act,
                                     want.cur, got.change, got.st, got.act, got.cur);
                    end
                end
            end
            outstanding = forcing_q.size();
        end
    end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [10:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         operation;
    logic [9:0]         entry_index;
    logic signed [31:0] entry_time;
    logic signed [31:0] entry_value;
    logic signed [31:0] query_year;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] change_value;
    logic [1:0]         status;
    logic               active;
    logic [10:0]        cursor_position;

    int errors, outstanding, results_seen, evals_seen, lerps_seen;
    bit idle_on;
    bit hold_go;
    int hold_left;
    logic signed [31:0] time_copy [ctinterp_pkg::TABLE_DEPTH];

    cursor_table_interpolator_top u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .entry_index     (entry_index),
        .entry_time      (entry_time),
        .entry_value     (entry_value),
        .query_year      (query_year),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .change_value    (change_value),
        .status          (status),
        .active          (active),
        .cursor_position (cursor_position)
    );

    cursor_table_checker u_chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .entry_index     (entry_index),
        .entry_time      (entry_time),
        .entry_value     (entry_value),
        .query_year      (query_year),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .change_value    (change_value),
        .status          (status),
        .active          (active),
        .cursor_position (cursor_position),
        .errors          (errors),
        .outstanding     (outstanding),
        .results_seen    (results_seen),
        .evals_seen      (evals_seen),
        .lerps_seen      (lerps_seen)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Receiver: random stalls, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_go)
        begin
            out_stall <= 1'b1;
            hold_left <= 300;
        end
        else
            out_stall <= idle_on && ($urandom_range(99) < 16);
    end

    initial
    begin
        #200ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Offer one beat, with an occasional idle gap ahead of it
    task automatic send_item(input logic [1:0] op, input logic [9:0] slot,
                             input logic [31:0] t, input logic [31:0] v,
                             input logic [31:0] q);
        if (idle_on && $urandom_range(99) < 16)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        entry_index <= slot;
        entry_time  <= t;
        entry_value <= v;
        query_year  <= q;
        if (op == ctinterp_pkg::OP_WRITE)
            time_copy[slot] = t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drain the block, then write one register
    task automatic set_reg(input logic [1:0] index, input logic [10:0] data);
        in_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (6) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Fill slots 0..n-1 with non-decreasing times and random values
    task automatic load_table(input int n);
        logic signed [31:0] t;
        t = $signed($urandom_range(0, 2 ** 21)) - 32'sd1048576;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) != 0)
                t = t + $urandom_range(1, 512);
            send_item(ctinterp_pkg::OP_WRITE, i[9:0], t, $urandom, $urandom);
        end
    endtask

    function automatic logic [31:0] query_near(input int n);
        logic [31:0] t;
        if (n == 0)
            return $urandom;
        t = time_copy[$urandom_range(0, n - 1)];
        case ($urandom_range(9))
            0, 1, 2, 3: return t;
            4, 5, 6:    return t + $urandom_range(1, 300);
            7:          return t - $urandom_range(1, 300);
            8:          return $urandom;
            default:    return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
        endcase
    endfunction

    // Mostly seeks and evaluates near table times, some writes and noise
    task automatic random_phase(input int n, input int len);
        int pick;
        int lim;
        lim = (len > ctinterp_pkg::TABLE_DEPTH) ? ctinterp_pkg::TABLE_DEPTH : len;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
                send_item(ctinterp_pkg::OP_EVAL, 10'($urandom), $urandom, $urandom,
                          query_near(lim));
            else if (pick < 80)
                send_item(ctinterp_pkg::OP_SEEK, 10'($urandom), $urandom, $urandom,
                          query_near(lim));
            else if (pick < 93)
                send_item(ctinterp_pkg::OP_WRITE, 10'($urandom), query_near(lim),
                          $urandom, $urandom);
            else
                send_item(2'd3, 10'($urandom), $urandom, $urandom, $urandom);
        end
    endtask

    initial
    begin
        clk         = 1'b1;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = ctinterp_pkg::REG_LENGTH;
        cfg_data    = '0;
        in_valid    = 1'b0;
        operation   = ctinterp_pkg::OP_WRITE;
        entry_index = '0;
        entry_time  = '0;
        entry_value = '0;
        query_year  = '0;
        out_stall   = 1'b0;
        idle_on     = 1'b1;
        hold_go     = 1'b0;
        hold_left   = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, unknown operation, top slot
        send_item(ctinterp_pkg::OP_SEEK, 0, 0, 0, 0);
        send_item(ctinterp_pkg::OP_EVAL, 0, 0, 0, 0);
        send_item(2'd3, 10'h3ff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        send_item(ctinterp_pkg::OP_WRITE, 10'h3ff, 32'h7fffffff, 32'h80000000, 0);
        // extreme times and values
        send_item(ctinterp_pkg::OP_WRITE, 0, 32'h80000000, 32'h7fffffff, 0);
        send_item(ctinterp_pkg::OP_WRITE, 1, 32'hffffff00, 32'h80000000, 0);
        send_item(ctinterp_pkg::OP_WRITE, 2, 32'h00000100, 32'h00010000, 0);
        send_item(ctinterp_pkg::OP_WRITE, 3, 32'h7fffffff, 32'hffff0000, 0);
        set_reg(ctinterp_pkg::REG_LENGTH, 11'd4);
        send_item(ctinterp_pkg::OP_EVAL, 0, 0, 0, 32'h80000000);
        send_item(ctinterp_pkg::OP_SEEK, 0, 0, 0, 32'h0);
        send_item(ctinterp_pkg::OP_EVAL, 0, 0, 0, 32'h0);
        send_item(ctinterp_pkg::OP_EVAL, 0, 0, 0, 32'h100);
        send_item(ctinterp_pkg::OP_EVAL, 0, 0, 0, 32'h7fffffff);
        // before start in each mode
        send_item(ctinterp_pkg::OP_WRITE, 0, -32'sd1000, 32'h00012345, 0);
        send_item(ctinterp_pkg::OP_SEEK, 0, 0, 0, -32'sd2000);
        send_item(ctinterp_pkg::OP_EVAL, 0, 0, 0, -32'sd1500);
        set_reg(ctinterp_pkg::REG_MODE, 11'(ctinterp_pkg::MODE_BACK));
        send_item(ctinterp_pkg::OP_EVAL, 0, 0, 0, -32'sd1500);
        set_reg(ctinterp_pkg::REG_MODE, 11'(ctinterp_pkg::MODE_FWD));
        send_item(ctinterp_pkg::OP_EVAL, 0, 0, 0, -32'sd1500);
        // extrapolation with the cursor ahead, mode three as linear
        set_reg(ctinterp_pkg::REG_MODE, 11'd3);
        send_item(ctinterp_pkg::OP_SEEK, 0, 0, 0, 32'h200);
        send_item(ctinterp_pkg::OP_EVAL, 0, 0, 0, -32'sd300);
        // equal neighbouring times, then past the end
        send_item(ctinterp_pkg::OP_WRITE, 2, 32'hffffff00, 32'h00070000, 0);
        set_reg(ctinterp_pkg::REG_LENGTH, 11'd3);
        send_item(ctinterp_pkg::OP_SEEK, 0, 0, 0, -32'sd256);
        send_item(ctinterp_pkg::OP_EVAL, 0, 0, 0, -32'sd300);
        send_item(ctinterp_pkg::OP_EVAL, 0, 0, 0, 32'h0);

        // random phases over several table settings
        load_table(6);
        set_reg(ctinterp_pkg::REG_LENGTH, 11'd6);
        set_reg(ctinterp_pkg::REG_MODE, 11'(ctinterp_pkg::MODE_BACK));
        random_phase(75, 6);

        load_table(12);
        set_reg(ctinterp_pkg::REG_LENGTH, 11'd12);
        set_reg(ctinterp_pkg::REG_MODE, 11'(ctinterp_pkg::MODE_FWD));
        random_phase(75, 12);

        load_table(1);
        set_reg(ctinterp_pkg::REG_LENGTH, 11'd1);
        set_reg(ctinterp_pkg::REG_MODE, 11'(ctinterp_pkg::MODE_LIN));
        random_phase(60, 1);

        load_table(40);
        set_reg(ctinterp_pkg::REG_LENGTH, 11'd40);
        set_reg(ctinterp_pkg::REG_MODE, 11'd3);
        random_phase(75, 40);

        // long receiver hold-off while the sender keeps offering
        load_table(20);
        set_reg(ctinterp_pkg::REG_LENGTH, 11'd20);
        set_reg(ctinterp_pkg::REG_MODE, 11'(ctinterp_pkg::MODE_BACK));
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
        random_phase(75, 20);

        set_reg(ctinterp_pkg::REG_LENGTH, 11'd0);
        set_reg(ctinterp_pkg::REG_MODE, 11'(ctinterp_pkg::MODE_FWD));
        random_phase(40, 0);

        // stretch with no idling on either side
        idle_on <= 1'b0;
        load_table(30);
        set_reg(ctinterp_pkg::REG_LENGTH, 11'd30);
        set_reg(ctinterp_pkg::REG_MODE, 11'(ctinterp_pkg::MODE_LIN));
        random_phase(85, 30);

        in_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (100) @(posedge clk);
        $display("Checked %0d result beats, including %0d evaluates (%0d interpolated),",
                 results_seen, evals_seen, lerps_seen);
        $display("across table lengths 0 to 40, every interpolation mode and a long hold-off.");
        if (errors == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
